FILE: hw/rtl/rpg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTP PTS generator package
// Shared widths, register indexes, controller states and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package rpg_pkg;

    localparam int TS_W       = 32;   // RTP timestamp
    localparam int WALL_W     = 48;   // wall-clock time
    localparam int GAP_W      = 32;   // gap length
    localparam int PTS_W      = 64;   // presentation timestamp
    localparam int WRATE_W    = 30;   // wall ticks per second
    localparam int RRATE_W    = 20;   // RTP ticks per second
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 30;
    localparam int IN_DATA_W  = TS_W + WALL_W + GAP_W;

    // The elapsed time is multiplied in two halves through one multiplier.
    localparam int MUL_SPLIT  = WALL_W / 2;
    localparam int PROD_W     = MUL_SPLIT + RRATE_W;
    // Numerator 2*t*r + w and divisor 2*w.
    localparam int NUM_W      = WALL_W + RRATE_W + 2;
    localparam int DEN_W      = WRATE_W + 1;
    localparam int DIV_CNT_W  = $clog2(NUM_W + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_WALL_RATE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RTP_RATE  = 1'b1;

    localparam logic [WRATE_W-1:0] WALL_RATE_RST = WRATE_W'(1000);
    localparam logic [RRATE_W-1:0] RTP_RATE_RST  = RRATE_W'(90000);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEL_T,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_SUM,
        ST_NUMER,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_ADJ,
        ST_DONE
    } rpg_state_t;

    typedef struct packed {
        logic load;       // capture the input beat
        logic sel_t;      // form the time span to convert
        logic mul_lo;     // low half product
        logic mul_hi;     // high half product
        logic sum;        // join the partial products
        logic numer;      // double and add the rounding term
        logic div_start;  // launch the serial divider
        logic adjust;     // form the amount to add, or the new gap sum
        logic commit;     // update state and the result register
    } rpg_cmd_t;

    typedef struct packed {
        logic kind;       // held beat is a gap report
        logic need_div;   // held beat needs a wall-to-RTP conversion
        logic div_done;   // quotient is ready
        logic out_busy;   // result register full and not taken this cycle
    } rpg_status_t;

endpackage

FILE: hw/rtl/rpg_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTP PTS generator serial divider
// Restoring divider, one quotient bit per cycle, NUM_W quotient bits per division.
// ----------------------------------------------------------------------------
module rpg_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [rpg_pkg::NUM_W-1:0]   dividend,
    input  logic [rpg_pkg::DEN_W-1:0]   divisor,
    output logic                        done,
    output logic [rpg_pkg::NUM_W-1:0]   quotient
);
    import rpg_pkg::*;

    logic [NUM_W-1:0]     quo_reg, quo_next;
    logic [DEN_W-1:0]     rem_reg, rem_next;
    logic [DEN_W-1:0]     den_reg, den_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 done_reg, done_next;
    logic [DEN_W:0]       rem_shift;
    logic [DEN_W:0]       diff;

    // The dividend shifts out at the top while quotient bits enter below.
    always_comb begin
        rem_shift = {rem_reg, quo_reg[NUM_W-1]};
        diff      = rem_shift - {1'b0, den_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next = dividend;
            rem_next = '0;
            den_next = divisor;
            cnt_next = DIV_CNT_W'(NUM_W);
        end else if (cnt_reg != '0) begin
            if (rem_shift >= {1'b0, den_reg}) begin
                rem_next = diff[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end else begin
                rem_next = rem_shift[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == DIV_CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: hw/rtl/rpg_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTP PTS generator datapath
// Rate registers, timestamp state, wall-to-RTP conversion and result register.
// ----------------------------------------------------------------------------
module rpg_dpath (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  rpg_pkg::rpg_cmd_t                cmd,
    output rpg_pkg::rpg_status_t             status,
    input  logic                             cfg_wr_en,
    input  logic [rpg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rpg_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    input  logic                             s_tuser,
    input  logic [rpg_pkg::IN_DATA_W-1:0]    s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [rpg_pkg::PTS_W-1:0]        m_tdata,
    output logic                             m_tuser
);
    import rpg_pkg::*;

    // Configuration
    logic [WRATE_W-1:0] wall_rate_reg, wall_rate_next;
    logic [RRATE_W-1:0] rtp_rate_reg, rtp_rate_next;
    logic [WRATE_W-1:0] wall_rate_eff;

    // Held beat
    logic               kind_reg, kind_next;
    logic [TS_W-1:0]    rtp_reg, rtp_next;
    logic [WALL_W-1:0]  wall_reg, wall_next;
    logic [GAP_W-1:0]   gap_reg, gap_next;

    // Conversion pipeline
    logic [WALL_W-1:0]    span_reg, span_next;
    logic [MUL_SPLIT-1:0] mul_a;
    logic [PROD_W-1:0]    prod;
    logic [PROD_W-1:0]    prod_lo_reg, prod_lo_next;
    logic [PROD_W-1:0]    prod_hi_reg, prod_hi_next;
    logic [NUM_W-1:0]     num_reg, num_next;
    logic [PTS_W-1:0]     adj_reg, adj_next;
    logic                 div_done;
    logic [NUM_W-1:0]     quotient;
    logic [PTS_W-1:0]     q64;

    // Architectural state
    logic [PTS_W-1:0]   pts_reg, pts_next;
    logic [TS_W-1:0]    last_rtp_reg, last_rtp_next;
    logic [WALL_W-1:0]  last_wall_reg, last_wall_next;
    logic [PTS_W-1:0]   gap_sum_reg, gap_sum_next;
    logic               gap_pending_reg, gap_pending_next;
    logic               wall_seen;
    logic [TS_W-1:0]    prev_rtp;
    logic [TS_W-1:0]    rtp_delta;

    // Result register
    logic               out_valid_reg, out_valid_next;
    logic [PTS_W-1:0]   out_pts_reg, out_pts_next;
    logic               out_rebased_reg, out_rebased_next;

    assign wall_rate_eff = (wall_rate_reg == '0) ? WRATE_W'(1) : wall_rate_reg;
    assign wall_seen     = (last_wall_reg != '0);
    assign prev_rtp      = (last_rtp_reg == '0) ? rtp_reg : last_rtp_reg;
    // The RTP delta wraps at the timestamp width before it is widened.
    assign rtp_delta     = rtp_reg - prev_rtp;
    assign q64           = quotient[PTS_W-1:0];

    // One multiplier serves both halves of the span.
    assign mul_a = cmd.mul_hi ? span_reg[WALL_W-1:MUL_SPLIT] : span_reg[MUL_SPLIT-1:0];
    assign prod  = PROD_W'(mul_a) * PROD_W'(rtp_rate_reg);

    rpg_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (num_reg),
        .divisor  ({wall_rate_eff, 1'b0}),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb begin
        wall_rate_next = wall_rate_reg;
        rtp_rate_next  = rtp_rate_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_WALL_RATE: wall_rate_next = cfg_wr_data[WRATE_W-1:0];
                CFG_RTP_RATE:  rtp_rate_next  = cfg_wr_data[RRATE_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb begin
        kind_next    = kind_reg;
        rtp_next     = rtp_reg;
        wall_next    = wall_reg;
        gap_next     = gap_reg;
        span_next    = span_reg;
        prod_lo_next = prod_lo_reg;
        prod_hi_next = prod_hi_reg;
        num_next     = num_reg;
        adj_next     = adj_reg;

        if (cmd.load) begin
            kind_next = s_tuser;
            rtp_next  = s_tdata[TS_W-1:0];
            wall_next = s_tdata[TS_W+WALL_W-1:TS_W];
            gap_next  = s_tdata[IN_DATA_W-1:TS_W+WALL_W];
        end
        // A backward wall step wraps modulo the wall width.
        if (cmd.sel_t) begin
            span_next = kind_reg ? WALL_W'(gap_reg) : (wall_reg - last_wall_reg);
        end
        if (cmd.mul_lo) begin
            prod_lo_next = prod;
        end
        if (cmd.mul_hi) begin
            prod_hi_next = prod;
        end
        if (cmd.sum) begin
            num_next = {2'b00, prod_hi_reg, {MUL_SPLIT{1'b0}}} + NUM_W'(prod_lo_reg);
        end
        if (cmd.numer) begin
            num_next = {num_reg[NUM_W-2:0], 1'b0} + NUM_W'(wall_rate_eff);
        end
        if (cmd.adjust) begin
            priority if (kind_reg) begin
                adj_next = gap_sum_reg + q64;
            end else if (gap_pending_reg && wall_seen) begin
                adj_next = q64 - gap_sum_reg;
            end else if (gap_pending_reg) begin
                adj_next = '0;
            end else begin
                adj_next = PTS_W'(rtp_delta);
            end
        end
    end

    always_comb begin
        pts_next         = pts_reg;
        last_rtp_next    = last_rtp_reg;
        last_wall_next   = last_wall_reg;
        gap_sum_next     = gap_sum_reg;
        gap_pending_next = gap_pending_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_pts_next     = out_pts_reg;
        out_rebased_next = out_rebased_reg;

        if (cmd.commit) begin
            if (kind_reg) begin
                gap_sum_next     = adj_reg;
                gap_pending_next = 1'b1;
            end else begin
                pts_next         = pts_reg + adj_reg;
                last_rtp_next    = rtp_reg;
                out_valid_next   = 1'b1;
                out_pts_next     = pts_reg + adj_reg;
                out_rebased_next = gap_pending_reg;
                if (gap_pending_reg) begin
                    gap_sum_next     = '0;
                    gap_pending_next = 1'b0;
                end else begin
                    last_wall_next = wall_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wall_rate_reg   <= WALL_RATE_RST;
            rtp_rate_reg    <= RTP_RATE_RST;
            pts_reg         <= '0;
            last_rtp_reg    <= '0;
            last_wall_reg   <= '0;
            gap_sum_reg     <= '0;
            gap_pending_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            wall_rate_reg   <= wall_rate_next;
            rtp_rate_reg    <= rtp_rate_next;
            pts_reg         <= pts_next;
            last_rtp_reg    <= last_rtp_next;
            last_wall_reg   <= last_wall_next;
            gap_sum_reg     <= gap_sum_next;
            gap_pending_reg <= gap_pending_next;
            out_valid_reg   <= out_valid_next;
        end
        kind_reg        <= kind_next;
        rtp_reg         <= rtp_next;
        wall_reg        <= wall_next;
        gap_reg         <= gap_next;
        span_reg        <= span_next;
        prod_lo_reg     <= prod_lo_next;
        prod_hi_reg     <= prod_hi_next;
        num_reg         <= num_next;
        adj_reg         <= adj_next;
        out_pts_reg     <= out_pts_next;
        out_rebased_reg <= out_rebased_next;
    end

    assign status.kind     = kind_reg;
    assign status.need_div = kind_reg || (gap_pending_reg && wall_seen);
    assign status.div_done = div_done;
    assign status.out_busy = out_valid_reg && !m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_pts_reg;
    assign m_tuser  = out_rebased_reg;

endmodule

FILE: hw/rtl/rpg_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTP PTS generator controller
// Sequences one beat at a time through conversion where needed, adjustment and commit.
// ----------------------------------------------------------------------------
module rpg_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  rpg_pkg::rpg_status_t  status,
    output rpg_pkg::rpg_cmd_t     cmd
);
    import rpg_pkg::*;

    rpg_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SEL_T;
                end
            end
            ST_SEL_T: begin
                cmd.sel_t  = 1'b1;
                state_next = status.need_div ? ST_MUL_LO : ST_ADJ;
            end
            ST_MUL_LO: begin
                cmd.mul_lo = 1'b1;
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI: begin
                cmd.mul_hi = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                cmd.sum    = 1'b1;
                state_next = ST_NUMER;
            end
            ST_NUMER: begin
                cmd.numer  = 1'b1;
                state_next = ST_DIV_GO;
            end
            ST_DIV_GO: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (status.div_done) begin
                    state_next = ST_ADJ;
                end
            end
            ST_ADJ: begin
                cmd.adjust = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // A gap beat gives no result, so it never waits on the output.
                if (status.kind || !status.out_busy) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: hw/rtl/rtp_pts_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTP PTS generator
// Builds a running 64-bit presentation timestamp from RTP timestamps, with
// wall-clock rebasing after reported gaps.
// ----------------------------------------------------------------------------
// Sequencing: after acceptance a plain timestamp beat passes SEL_T, ADJ and DONE;
// one taking the wall-to-RTP path also passes the multiply, numerator and divider
// states; a gap beat gives no result. One beat at a time is in flight, the next
// taken only in IDLE; conversions go through the bit-serial 70-step divider.
// Reset: aresetn, synchronous, clears the PTS, timestamp and gap state, sets
// the rates to 1000 and 90000 ticks per second; no clearing pass is needed.
// ----------------------------------------------------------------------------
module rtp_pts_generator (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Configuration
    input  logic                             cfg_wr_en,
    input  logic [rpg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rpg_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    // Input beats
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [rpg_pkg::IN_DATA_W-1:0]    s_tdata,  // rtp_timestamp, wall_clock, gap_duration
    input  logic                             s_tuser,  // kind
    // Results
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [rpg_pkg::PTS_W-1:0]        m_tdata,  // pts
    output logic                             m_tuser   // rebased
);
    import rpg_pkg::*;

    rpg_cmd_t    cmd;
    rpg_status_t status;

    rpg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rpg_dpath u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tuser     (s_tuser),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule
